// ===== rtl/core/interval_room_allocator_core_defines.svh =====
// Assertion macros for the interval room allocator core.
`ifndef INTERVAL_ROOM_ALLOCATOR_CORE_DEFINES_SVH
`define INTERVAL_ROOM_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on i_clk, off during reset
`define IRA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("interval room allocator check failed");

// Next-cycle implication, sampled on i_clk, off during reset
`define IRA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("interval room allocator check failed");

`else

`define IRA_ASSERT_IMP(lbl, ante, cons)

`define IRA_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/core/ira_pkg.sv =====
// Shared constants and types of the interval room allocator.
package ira_pkg;

    // Fixed field widths
    localparam int ID_W      = 20;
    localparam int IN_TIME_W = 32;
    localparam int OUT_W     = 11;

    // Per-cycle command broadcast along the cell chain
    typedef struct packed {
        logic clr;   // batch start: drop every entry
        logic ins;   // sorted insert of the broadcast key
        logic rep;   // drop the head, insert the broadcast key
    } t_cell_ctrl;

endpackage

// ===== rtl/core/ira_cell.sv =====
// One cell of the sorted room chain: holds one (departure, id, room) entry.
module ira_cell #(
    parameter int TW = 32,
    parameter int RW = 11
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ira_pkg::t_cell_ctrl       i_ctrl,
    input  logic                      i_head,
    // broadcast key
    input  logic [TW-1:0]             i_k_dep,
    input  logic [ira_pkg::ID_W-1:0]  i_k_id,
    input  logic [RW-1:0]             i_k_room,
    // left neighbour (towards the head)
    input  logic                      i_prev_valid,
    input  logic                      i_prev_lt,
    input  logic [TW-1:0]             i_prev_dep,
    input  logic [ira_pkg::ID_W-1:0]  i_prev_id,
    input  logic [RW-1:0]             i_prev_room,
    // right neighbour (towards the tail)
    input  logic                      i_next_lt,
    input  logic [TW-1:0]             i_next_dep,
    input  logic [ira_pkg::ID_W-1:0]  i_next_id,
    input  logic [RW-1:0]             i_next_room,
    // own entry
    output logic                      o_valid,
    output logic                      o_lt,
    output logic [TW-1:0]             o_dep,
    output logic [ira_pkg::ID_W-1:0]  o_id,
    output logic [RW-1:0]             o_room
);

    logic                     r_valid;
    logic [TW-1:0]            r_dep;
    logic [ira_pkg::ID_W-1:0] r_id;
    logic [RW-1:0]            r_room;

    logic                     n_valid;
    logic [TW-1:0]            n_dep;
    logic [ira_pkg::ID_W-1:0] n_id;
    logic [RW-1:0]            n_room;

    logic w_v_eff;
    logic w_pv_eff;
    logic w_lt;

    // Occupancy as seen this cycle; a batch start empties the chain
    assign w_v_eff  = r_valid & ~i_ctrl.clr;
    assign w_pv_eff = (i_prev_valid & ~i_ctrl.clr) | i_head;

    // Entry sorts strictly before the broadcast key
    assign w_lt = w_v_eff && ({r_dep, r_id, r_room} < {i_k_dep, i_k_id, i_k_room});

    // Next entry: keep, take the key, or shift from a neighbour
    always_comb begin
        n_valid = r_valid;
        n_dep   = r_dep;
        n_id    = r_id;
        n_room  = r_room;
        if (i_ctrl.ins) begin
            if (!w_lt) begin
                if (i_prev_lt) begin
                    n_dep  = i_k_dep;
                    n_id   = i_k_id;
                    n_room = i_k_room;
                end else begin
                    n_dep  = i_prev_dep;
                    n_id   = i_prev_id;
                    n_room = i_prev_room;
                end
            end
            n_valid = w_v_eff | w_pv_eff;
        end else if (i_ctrl.rep) begin
            if (i_next_lt) begin
                n_dep  = i_next_dep;
                n_id   = i_next_id;
                n_room = i_next_room;
            end else if (i_head || w_lt) begin
                n_dep  = i_k_dep;
                n_id   = i_k_id;
                n_room = i_k_room;
            end
            n_valid = w_v_eff;
        end else if (i_ctrl.clr) begin
            n_valid = 1'b0;
        end
    end

    // Occupancy bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Entry payload
    always_ff @(posedge i_clk) begin
        r_dep  <= n_dep;
        r_id   <= n_id;
        r_room <= n_room;
    end

    assign o_valid = r_valid;
    assign o_lt    = w_lt;
    assign o_dep   = r_dep;
    assign o_id    = r_id;
    assign o_room  = r_room;

endmodule

// ===== rtl/core/interval_room_allocator_core.sv =====
// Top level of the interval room allocator: control, output register and cell chain.
`include "interval_room_allocator_core_defines.svh"

// Greedy room allocator. Requests (arrival, departure, customer id) should arrive sorted
// by arrival, then departure, then id. Open rooms live in a chain of MAX_ROOMS cells kept
// sorted by (departure, id, room number), so the head cell always holds the room that
// frees first. A request whose arrival is strictly later than the head departure reuses
// that room; otherwise a new room is opened, or overflow is flagged with room 0 when all
// MAX_ROOMS rooms are open. batch_start empties the chain before the request is handled.
// On acceptance of a request the arrival is compared with the head cell and the decision
// is fixed; in the execute state that follows, every cell compares its entry with the new
// key and shifts by at most one place. One request is in flight at a time; the result sits
// in an output register, and a stalled result keeps the request in the execute state.
// The request input is stalled while reset is held.
// No clearing pass is needed after reset. Room numbers and counts are given modulo 2048.
module interval_room_allocator_core #(
    parameter int MAX_ROOMS = 1024,
    parameter int TIME_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_batch_start,
    input  logic [ira_pkg::IN_TIME_W-1:0] i_arrival_time,
    input  logic [ira_pkg::IN_TIME_W-1:0] i_departure_time,
    input  logic [ira_pkg::ID_W-1:0]      i_customer_id,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ira_pkg::OUT_W-1:0]     o_assigned_room,
    output logic [ira_pkg::OUT_W-1:0]     o_rooms_in_use,
    output logic                          o_overflow
);

    localparam int CW = $clog2(MAX_ROOMS + 1);
    localparam int TW = TIME_BITS;

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_EXEC = 1'b1;

    // Control state
    logic [0:0]  r_state;
    logic [0:0]  n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic        r_out_valid;
    logic        n_out_valid;

    // Decision held from acceptance until the request fires
    logic                     r_start;
    logic                     r_reuse;
    logic                     r_ins;
    logic                     r_ovf;
    logic [TW-1:0]            r_k_dep;
    logic [ira_pkg::ID_W-1:0] r_k_id;
    logic [CW-1:0]            r_k_room;
    logic [CW-1:0]            r_cnt_next;

    // Result register
    logic [CW-1:0] r_out_room;
    logic [CW-1:0] r_out_used;
    logic          r_out_ovf;

    logic w_in_acc;
    logic w_fire;

    // Chain taps: element 0 is the tie-off left of the head, element k is cell k-1,
    // element MAX_ROOMS+1 is the tie-off right of the tail
    logic                     s_valid [0:MAX_ROOMS+1];
    logic                     s_lt    [0:MAX_ROOMS+1];
    logic [TW-1:0]            s_dep   [0:MAX_ROOMS+1];
    logic [ira_pkg::ID_W-1:0] s_id    [0:MAX_ROOMS+1];
    logic [CW-1:0]            s_room  [0:MAX_ROOMS+1];
    logic [MAX_ROOMS-1:0]     w_occ;

    ira_pkg::t_cell_ctrl w_ctrl;

    // Input time fields reduced to TIME_BITS
    logic [TW+ira_pkg::IN_TIME_W-1:0] w_arr_ext;
    logic [TW+ira_pkg::IN_TIME_W-1:0] w_dep_ext;
    logic [TW-1:0]                    w_arr;
    logic [TW-1:0]                    w_dep;

    assign w_arr_ext = {{TW{1'b0}}, i_arrival_time};
    assign w_dep_ext = {{TW{1'b0}}, i_departure_time};
    assign w_arr     = w_arr_ext[TW-1:0];
    assign w_dep     = w_dep_ext[TW-1:0];

    // Handshakes; no request is taken while reset is held
    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_fire     = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    // Decision against the head cell, taken at acceptance
    logic          w_head_v;
    logic          w_reuse;
    logic          w_full;
    logic          w_ins;
    logic [CW-1:0] w_cnt_eff;
    logic [CW-1:0] w_cnt_inc;

    assign w_cnt_eff = i_batch_start ? '0 : r_count;
    assign w_cnt_inc = w_cnt_eff + CW'(1);
    assign w_head_v  = s_valid[1] & ~i_batch_start;
    assign w_reuse   = w_head_v && (s_dep[1] < w_arr);
    assign w_full    = (w_cnt_eff == CW'(MAX_ROOMS));
    assign w_ins     = !w_reuse && !w_full;

    // Next control state
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_fire) begin
                    n_state     = S_IDLE;
                    n_count     = r_cnt_next;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Request decision and key
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_start    <= i_batch_start;
            r_reuse    <= w_reuse;
            r_ins      <= w_ins;
            r_ovf      <= !w_reuse && w_full;
            r_k_dep    <= w_dep;
            r_k_id     <= i_customer_id;
            r_k_room   <= w_reuse ? s_room[1] : w_cnt_inc;
            r_cnt_next <= w_ins ? w_cnt_inc : w_cnt_eff;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_room <= r_ovf ? '0 : r_k_room;
            r_out_used <= r_cnt_next;
            r_out_ovf  <= r_ovf;
        end
    end

    // Chain command, issued when the request fires
    assign w_ctrl.clr = w_fire && r_start;
    assign w_ctrl.ins = w_fire && r_ins;
    assign w_ctrl.rep = w_fire && r_reuse;

    // Tie-offs at both ends of the chain
    assign s_valid[0]           = 1'b0;
    assign s_lt[0]              = 1'b1;
    assign s_dep[0]             = '0;
    assign s_id[0]              = '0;
    assign s_room[0]            = '0;
    assign s_valid[MAX_ROOMS+1] = 1'b0;
    assign s_lt[MAX_ROOMS+1]    = 1'b0;
    assign s_dep[MAX_ROOMS+1]   = '0;
    assign s_id[MAX_ROOMS+1]    = '0;
    assign s_room[MAX_ROOMS+1]  = '0;

    // Row of cells
    for (genvar gi = 0; gi < MAX_ROOMS; gi++) begin : g_cell
        ira_cell #(
            .TW (TW),
            .RW (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_head       (gi == 0),
            .i_k_dep      (r_k_dep),
            .i_k_id       (r_k_id),
            .i_k_room     (r_k_room),
            .i_prev_valid (s_valid[gi]),
            .i_prev_lt    (s_lt[gi]),
            .i_prev_dep   (s_dep[gi]),
            .i_prev_id    (s_id[gi]),
            .i_prev_room  (s_room[gi]),
            .i_next_lt    (s_lt[gi+2]),
            .i_next_dep   (s_dep[gi+2]),
            .i_next_id    (s_id[gi+2]),
            .i_next_room  (s_room[gi+2]),
            .o_valid      (s_valid[gi+1]),
            .o_lt         (s_lt[gi+1]),
            .o_dep        (s_dep[gi+1]),
            .o_id         (s_id[gi+1]),
            .o_room       (s_room[gi+1])
        );
        assign w_occ[gi] = s_valid[gi+1];
    end

    // Outputs, room number and count given modulo 2048
    logic [CW+ira_pkg::OUT_W-1:0] w_room_ext;
    logic [CW+ira_pkg::OUT_W-1:0] w_used_ext;

    assign w_room_ext      = {{ira_pkg::OUT_W{1'b0}}, r_out_room};
    assign w_used_ext      = {{ira_pkg::OUT_W{1'b0}}, r_out_used};
    assign o_out_valid     = r_out_valid;
    assign o_assigned_room = w_room_ext[ira_pkg::OUT_W-1:0];
    assign o_rooms_in_use  = w_used_ext[ira_pkg::OUT_W-1:0];
    assign o_overflow      = r_out_ovf;

    // Checks
    `IRA_ASSERT_IMP(a_occ_matches_count, 1'b1, $countones(w_occ) == int'(r_count))
    `IRA_ASSERT_NXT(a_accept_blocks_next, w_in_acc, o_in_stall)
    `IRA_ASSERT_NXT(a_fire_commits_count, w_fire, r_count == $past(r_cnt_next))
    `IRA_ASSERT_IMP(a_ovf_only_when_full, r_out_valid && r_out_ovf, r_out_used == CW'(MAX_ROOMS))
    `IRA_ASSERT_IMP(a_room_nonzero, r_out_valid && !r_out_ovf, r_out_room != '0)
    `IRA_ASSERT_IMP(a_room_within_open, r_out_valid && !r_out_ovf, r_out_room <= r_out_used)

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the interval room allocator core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROOM_CAP   = 1024;
    localparam int TIME_W     = 32;
    localparam int REQ_TARGET = 1950;
    localparam int FULL_BATCH = 1030;   // enough to fill the table and overflow
    localparam int HOLD_AT    = 200;    // result count at which the long hold-off starts
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_WAIT = 16;

    typedef struct packed {
        logic [ira_pkg::OUT_W-1:0] room;
        logic [ira_pkg::OUT_W-1:0] in_use;
        logic                      ovf;
    } t_room_grant;

    // Greedy room predictor plus the queue of grants still owed by the block
    class room_scoreboard;
        logic [TIME_W-1:0]        leave_at [ROOM_CAP];
        logic [ira_pkg::ID_W-1:0] occupant [ROOM_CAP];
        int unsigned              open_cnt;
        t_room_grant              owed [$];
        int                       errors;

        function new();
            open_cnt = 0;
            errors   = 0;
        endfunction

        // Allocate a room for an accepted request and queue the expected grant
        function void note_request(logic start, logic [TIME_W-1:0] arr,
                                   logic [TIME_W-1:0] dep, logic [ira_pkg::ID_W-1:0] id);
            int unsigned best;
            int unsigned granted;
            logic        ovf;
            t_room_grant g;
            granted = 0;
            ovf     = 1'b0;
            if (start)
                open_cnt = 0;
            // room that frees first; on equal departures the lowest occupant id, then the lowest number
            if (open_cnt > 0) begin
                best = 0;
                for (int unsigned r = 1; r < open_cnt; r++) begin
                    if (leave_at[r] < leave_at[best] ||
                        (leave_at[r] == leave_at[best] && occupant[r] < occupant[best]))
                        best = r;
                end
                if (leave_at[best] < arr) begin
                    leave_at[best] = dep;
                    occupant[best] = id;
                    granted        = best + 1;
                end
            end
            // no reusable room: open one, or flag a full table
            if (granted == 0) begin
                if (open_cnt < ROOM_CAP) begin
                    leave_at[open_cnt] = dep;
                    occupant[open_cnt] = id;
                    open_cnt++;
                    granted = open_cnt;
                end else begin
                    ovf = 1'b1;
                end
            end
            g.room   = granted[ira_pkg::OUT_W-1:0];
            g.in_use = open_cnt[ira_pkg::OUT_W-1:0];
            g.ovf    = ovf;
            owed.insert(owed.size(), g);
        endfunction

        // Compare one accepted grant with the oldest expectation
        function void check_result(logic [ira_pkg::OUT_W-1:0] room,
                                   logic [ira_pkg::OUT_W-1:0] in_use, logic ovf);
            t_room_grant want;
            if (owed.size() == 0) begin
                $display("%0t: grant with nothing expected: room %0d, in use %0d, ovf %0b",
                         $time, room, in_use, ovf);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (room !== want.room) begin
                $display("%0t: assigned_room expected %0d actual %0d", $time, want.room, room);
                errors++;
            end
            if (in_use !== want.in_use) begin
                $display("%0t: rooms_in_use expected %0d actual %0d",
                         $time, want.in_use, in_use);
                errors++;
            end
            if (ovf !== want.ovf) begin
                $display("%0t: overflow expected %0b actual %0b", $time, want.ovf, ovf);
                errors++;
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          req_valid = 1'b0;
    logic                          req_stall;
    logic                          req_start = 1'b0;
    logic [ira_pkg::IN_TIME_W-1:0] req_arrival = '0;
    logic [ira_pkg::IN_TIME_W-1:0] req_departure = '0;
    logic [ira_pkg::ID_W-1:0]      req_id = '0;
    logic                          grant_valid;
    logic                          grant_stall = 1'b0;
    logic [ira_pkg::OUT_W-1:0]     grant_room;
    logic [ira_pkg::OUT_W-1:0]     grant_in_use;
    logic                          grant_ovf;

    room_scoreboard ledger = new();
    int unsigned    req_sent = 0;
    int unsigned    grants_seen = 0;
    bit             tx_quiet = 1'b0;
    bit             rx_quiet = 1'b0;

    interval_room_allocator_core #(
        .MAX_ROOMS(ROOM_CAP),
        .TIME_BITS(TIME_W)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (req_valid),
        .o_in_stall      (req_stall),
        .i_batch_start   (req_start),
        .i_arrival_time  (req_arrival),
        .i_departure_time(req_departure),
        .i_customer_id   (req_id),
        .o_out_valid     (grant_valid),
        .i_out_stall     (grant_stall),
        .o_assigned_room (grant_room),
        .o_rooms_in_use  (grant_in_use),
        .o_overflow      (grant_ovf)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Wait drawn per request or grant; quiet spells give back-to-back traffic
    function automatic int unsigned draw_wait(bit quiet);
        return quiet ? 0 : $urandom_range(0, 19);
    endfunction

    // Offer one request after a random gap and hold it until the block takes it
    task automatic send_request(logic start, logic [ira_pkg::IN_TIME_W-1:0] arr,
                                logic [ira_pkg::IN_TIME_W-1:0] dep,
                                logic [ira_pkg::ID_W-1:0] id);
        int unsigned gap;
        if ($urandom_range(0, 49) == 0)
            tx_quiet = !tx_quiet;
        gap = draw_wait(tx_quiet);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid     <= 1'b1;
        req_start     <= start;
        req_arrival   <= arr;
        req_departure <= dep;
        req_id        <= id;
        do @(posedge clk); while (req_stall);
        ledger.note_request(start, arr, dep, id);
        req_sent++;
    endtask

    // Receiver: stall per grant, one long hold-off to back the block up
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n) begin
                if (grant_valid && !grant_stall) begin
                    ledger.check_result(grant_room, grant_in_use, grant_ovf);
                    grants_seen++;
                    if ($urandom_range(0, 49) == 0)
                        rx_quiet = !rx_quiet;
                    hold_left = (grants_seen == HOLD_AT) ? HOLD_LEN : draw_wait(rx_quiet);
                end else if (hold_left > 0) begin
                    hold_left--;
                end
                grant_stall <= (hold_left > 0);
            end
        end
    end

    // Stimulus and end of run
    initial begin
        logic [ira_pkg::IN_TIME_W-1:0] base;
        logic [ira_pkg::IN_TIME_W-1:0] arr;
        logic [ira_pkg::IN_TIME_W-1:0] dep;
        logic [ira_pkg::IN_TIME_W-1:0] prev_arr;
        logic [ira_pkg::IN_TIME_W-1:0] prev_dep;
        logic [ira_pkg::IN_TIME_W-1:0] dur;
        logic [ira_pkg::ID_W-1:0]      id_base;
        logic [ira_pkg::ID_W-1:0]      id;
        int unsigned                   len;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, reuse, equal departures, equal keys, extremes
        send_request(1'b0, 32'd0, 32'd0, 20'd0);
        send_request(1'b0, 32'd0, 32'd0, 20'hFFFFF);
        send_request(1'b0, 32'd1, 32'd5, 20'd3);
        send_request(1'b0, 32'd1, 32'd5, 20'd2);
        send_request(1'b0, 32'd6, 32'd9, 20'd7);
        send_request(1'b0, 32'd6, 32'd9, 20'd7);
        send_request(1'b0, 32'd10, 32'd20, 20'd1);
        send_request(1'b0, 32'd9, 32'd9, 20'd4);       // arrival equals head departure
        send_request(1'b0, 32'd100, 32'd50, 20'd5);    // departure below arrival
        send_request(1'b0, 32'd3, 32'd4, 20'd6);       // out of order
        send_request(1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 20'hFFFFF);
        send_request(1'b0, 32'hFFFFFFFF, 32'd0, 20'd0);
        send_request(1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 20'd0);
        send_request(1'b1, 32'd0, 32'hFFFFFFFF, 20'hFFFFF);
        send_request(1'b1, 32'd0, 32'hFFFFFFFF, 20'd0);
        send_request(1'b0, 32'h55555555, 32'hAAAAAAAA, 20'h55555);
        send_request(1'b0, 32'hAAAAAAAA, 32'hFFFFFFFF, 20'hAAAAA);
        send_request(1'b1, 32'h80000000, 32'h80000000, 20'h80000);
        send_request(1'b0, 32'h80000001, 32'h80000002, 20'h80000);

        // fill the whole table, overflow, then reuse while full
        base = $urandom_range(0, 32'hF0000000);
        for (int unsigned k = 0; k < FULL_BATCH; k++)
            send_request(k == 0, base, base + k, k[ira_pkg::ID_W-1:0]);
        for (int unsigned j = 1; j <= 60; j++)
            send_request(1'b0, base + 20 * j, base + 20 * j + $urandom_range(0, 40),
                         20'(FULL_BATCH + j));

        // random batches of sorted requests, with some noise
        while (req_sent < REQ_TARGET) begin
            if ($urandom_range(0, 9) == 0) begin
                send_request($urandom_range(0, 7) == 0, $urandom, $urandom,
                             20'($urandom_range(0, 20'hFFFFF)));
            end else begin
                len      = $urandom_range(1, 40);
                arr      = $urandom;
                id_base  = 20'($urandom_range(0, 20'hFFFFF));
                prev_arr = arr;
                prev_dep = '0;
                id       = id_base;
                for (int unsigned k = 0; k < len; k++) begin
                    if (k > 0 && $urandom_range(0, 3) != 0)
                        arr = arr + $urandom_range(1, 8);
                    dur = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 24);
                    dep = arr + dur;
                    if (k > 0 && arr == prev_arr && dep < prev_dep)
                        dep = prev_dep;
                    if (k == 0 || $urandom_range(0, 15) != 0)
                        id = id_base + k[ira_pkg::ID_W-1:0];
                    send_request(k == 0, arr, dep, id);
                    prev_arr = arr;
                    prev_dep = dep;
                end
            end
        end

        req_valid <= 1'b0;
        while (ledger.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (ledger.errors == 0)
            $display("interval_room_allocator_core regression: pass");
        else
            $display("interval_room_allocator_core regression: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("interval_room_allocator_core regression: fail");
        $finish;
    end

endmodule
